// File: sv/mtef_pkg.sv
`default_nettype none

package mtef_pkg;

  // Character codes that the filter recognizes.
  localparam logic [7:0] CharBslash  = 8'h5C;
  localparam logic [7:0] CharLParen  = 8'h28;
  localparam logic [7:0] CharRParen  = 8'h29;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowF    = 8'h66;
  localparam logic [7:0] CharLowZ    = 8'h7A;

  // Letters A-F count from eleven in the escape digit mapping.
  localparam logic [7:0] QuirkyBase  = 8'd11;

  // Most results that one input beat may produce.
  localparam logic [5:0] ResultCap   = 6'd36;

  // Configuration port layout and register indexes.
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam logic [CfgIdxW-1:0] CfgHexEn   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRussian = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDigits  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       stage_overflow;
  } out_item_t;

  // Classification of one buffered character.
  typedef struct packed {
    logic       is_blank;
    logic       is_bslash;
    logic       is_lparen;
    logic       is_rparen;
    logic       hex_ok;
    logic [4:0] hex_val;
    logic       forbidden;
  } cls_t;

endpackage

`default_nettype wire

// File: sv/mtef_ram.sv
`default_nettype none

module mtef_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/mtef_classify.sv
`default_nettype none

module mtef_classify (
  input  wire logic [7:0]   char_i,
  input  wire logic         russian_i,
  input  wire logic         digits_i,
  output mtef_pkg::cls_t    cls_o
);

  import mtef_pkg::*;

  logic       is_digit;
  logic       is_upper_hex;
  logic       is_lower_hex;
  logic       is_lower;
  logic       bad_digit;
  logic [7:0] up_val;
  logic [7:0] low_val;

  // Range compares shared by several of the classification outputs.
  assign is_digit     = (char_i >= CharZero) && (char_i <= CharNine);
  assign is_upper_hex = (char_i >= CharUpA) && (char_i <= CharUpF);
  assign is_lower_hex = (char_i >= CharLowA) && (char_i <= CharLowF);
  assign is_lower     = (char_i >= CharLowA) && (char_i <= CharLowZ);
  assign bad_digit    = is_digit && !digits_i;

  // Letter digits count from eleven upward.
  assign up_val  = char_i - CharUpA + QuirkyBase;
  assign low_val = char_i - CharLowA + QuirkyBase;

  always_comb begin
    cls_o.is_blank  = (char_i == CharSpace) || (char_i == CharCr) || (char_i == CharLf);
    cls_o.is_bslash = (char_i == CharBslash);
    cls_o.is_lparen = (char_i == CharLParen);
    cls_o.is_rparen = (char_i == CharRParen);
    cls_o.hex_ok    = is_digit || is_upper_hex || is_lower_hex;
    if (is_upper_hex) begin
      cls_o.hex_val = up_val[4:0];
    end else if (is_lower_hex) begin
      cls_o.hex_val = low_val[4:0];
    end else begin
      cls_o.hex_val = char_i[4:0] - CharZero[4:0];
    end
    // Lowercase letters and disallowed digits always reject a stage direction;
    // the strict rule also rejects every byte from 0x61 up.
    cls_o.forbidden = is_lower || bad_digit || (russian_i && (char_i >= CharLowA));
  end

endmodule

`default_nettype wire

// File: sv/message_text_escape_filter.sv
// Message text escape filter.
// Input channel: in_valid_i / in_stall_o carry one character per beat with a
// flag on the last character of a string. Output channel: out_valid_o /
// out_stall_i carry the processed characters; the final result of a string
// has end_of_string set, and a string whose last beat yields nothing ends
// with one bare result whose byte_valid is 0. Configuration writes use
// cfg_valid_i / cfg_ready_o (always ready) and may only be issued while the
// block is idle. Each input beat is held in a circular lookahead memory and
// the pending bytes are rescanned by a sequencer that reads one byte every
// cycle through the shared character classifier. The sequencer reads an
// accepted ordinary character, places its result in the pending slot and
// moves it on to the output register, and takes no new character until it
// is back in idle. A rejected stage candidate holding further '(' bytes is
// rescanned once per '('. Results leave through an output register, so a
// stalled receiver only holds the sequencer when it has a new result to pass.
// Reset clears the configuration to its defaults and empties the buffer.
`default_nettype none

module message_text_escape_filter #(
  parameter int unsigned STAGE_DEPTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire mtef_pkg::in_item_t                in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output mtef_pkg::out_item_t                    out_item_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mtef_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [mtef_pkg::CfgDataW-1:0]     cfg_data_i
);

  import mtef_pkg::*;

  localparam int unsigned IdxW = $clog2(STAGE_DEPTH);
  localparam int unsigned CntW = $clog2(STAGE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TOP  = 4'd1;
  localparam logic [3:0] S_C0   = 4'd2;
  localparam logic [3:0] S_H1   = 4'd3;
  localparam logic [3:0] S_H2   = 4'd4;
  localparam logic [3:0] S_L1   = 4'd5;
  localparam logic [3:0] S_PS   = 4'd6;
  localparam logic [3:0] S_PD   = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  // Offset from the buffer head, wrapped into the circular memory.
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = {{(CntW + 1 - IdxW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CntW + 1)'(STAGE_DEPTH)) begin
      sum = sum - (CntW + 1)'(STAGE_DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            end_q, end_d;
  logic            smode_q, smode_d;
  logic [CntW-1:0] j_q, j_d;
  logic [7:0]      b1_q, b1_d;
  logic [4:0]      d1_q, d1_d;
  logic            d1ok_q, d1ok_d;
  logic [7:0]      em_byte_q, em_byte_d;
  logic            em_ovf_q, em_ovf_d;
  logic [5:0]      n_q, n_d;
  logic            pend_valid_q, pend_valid_d;
  logic [7:0]      pend_byte_q, pend_byte_d;
  logic            pend_ovf_q, pend_ovf_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            hex_en_q, rus_q, dig_q;

  logic            out_free;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [CntW-1:0] rd_off;
  logic [IdxW-1:0] raddr;
  logic [7:0]      rdata;
  logic            adv_en;
  logic [CntW-1:0] adv_k;
  logic            emit_go;
  logic [7:0]      emit_byte;
  logic            emit_ovf;
  cls_t            cls;

  // Lookahead buffer of undecided characters.
  mtef_ram #(
    .Width (8),
    .Depth (STAGE_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.in_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared classifier on the byte just read.
  mtef_classify u_cls (
    .char_i    (rdata),
    .russian_i (rus_q),
    .digits_i  (dig_q),
    .cls_o     (cls)
  );

  assign waddr       = wrap_add(head_q, cnt_q);
  assign raddr       = wrap_add(head_q, rd_off);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Sequencer: decides one rule at a time from the head of the buffer.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    end_d        = end_q;
    smode_d      = smode_q;
    j_d          = j_q;
    b1_d         = b1_q;
    d1_d         = d1_q;
    d1ok_d       = d1ok_q;
    em_byte_d    = em_byte_q;
    em_ovf_d     = em_ovf_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    pend_ovf_d   = pend_ovf_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    we           = 1'b0;
    rd_off       = '0;
    adv_en       = 1'b0;
    adv_k        = '0;
    emit_go      = 1'b0;
    emit_byte    = 8'h00;
    emit_ovf     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q < CntW'(STAGE_DEPTH)) begin
            we    = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          end_d   = in_item_i.last_in;
          n_d     = '0;
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        rd_off = '0;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_C0;
        end
      end
      S_C0: begin
        if (smode_q && cls.is_blank) begin
          // Blanks after a dropped stage direction are swallowed.
          adv_en  = 1'b1;
          adv_k   = CntW'(1);
          state_d = S_TOP;
        end else begin
          smode_d = 1'b0;
          if (cls.is_bslash) begin
            if (hex_en_q && (cnt_q >= CntW'(3))) begin
              rd_off  = CntW'(1);
              state_d = S_H1;
            end else if (hex_en_q && !end_q) begin
              state_d = S_FIN;
            end else if (cnt_q >= CntW'(2)) begin
              rd_off  = CntW'(1);
              state_d = S_L1;
            end else if (!end_q) begin
              state_d = S_FIN;
            end else begin
              emit_go   = 1'b1;
              emit_byte = CharBslash;
              adv_en    = 1'b1;
              adv_k     = CntW'(1);
            end
          end else if (cls.is_lparen) begin
            j_d     = CntW'(1);
            state_d = S_PS;
          end else begin
            emit_go   = 1'b1;
            emit_byte = rdata;
            adv_en    = 1'b1;
            adv_k     = CntW'(1);
          end
        end
      end
      S_H1: begin
        b1_d    = rdata;
        d1_d    = cls.hex_val;
        d1ok_d  = cls.hex_ok;
        rd_off  = CntW'(2);
        state_d = S_H2;
      end
      S_H2: begin
        emit_go = 1'b1;
        adv_en  = 1'b1;
        if (d1ok_q && cls.hex_ok) begin
          emit_byte = {d1_q[3:0], 4'b0000} + {3'b000, cls.hex_val};
          adv_k     = CntW'(3);
        end else begin
          emit_byte = b1_q;
          adv_k     = CntW'(2);
        end
      end
      S_L1: begin
        emit_go   = 1'b1;
        emit_byte = rdata;
        adv_en    = 1'b1;
        adv_k     = CntW'(2);
      end
      S_PS: begin
        if (j_q < cnt_q) begin
          rd_off  = j_q;
          state_d = S_PD;
        end else if (end_q) begin
          emit_go   = 1'b1;
          emit_byte = CharLParen;
          adv_en    = 1'b1;
          adv_k     = CntW'(1);
        end else if (cnt_q >= CntW'(STAGE_DEPTH)) begin
          // Candidate filled the whole buffer: give up on it.
          emit_go   = 1'b1;
          emit_byte = CharLParen;
          emit_ovf  = 1'b1;
          adv_en    = 1'b1;
          adv_k     = CntW'(1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_PD: begin
        if (cls.is_rparen) begin
          adv_en  = 1'b1;
          adv_k   = j_q + CntW'(1);
          smode_d = 1'b1;
          state_d = S_TOP;
        end else if (cls.forbidden) begin
          emit_go   = 1'b1;
          emit_byte = CharLParen;
          adv_en    = 1'b1;
          adv_k     = CntW'(1);
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = S_PS;
        end
      end
      S_EMIT: begin
        // The newest result waits in the pending slot until it is known
        // whether it closes the string.
        if (n_q >= ResultCap) begin
          state_d = S_TOP;
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_byte_d  = em_byte_q;
          pend_ovf_d   = em_ovf_q;
          n_d          = n_q + 6'd1;
          state_d      = S_TOP;
        end else if (out_free) begin
          out_valid_d              = 1'b1;
          out_d.out_byte           = pend_byte_q;
          out_d.byte_valid         = 1'b1;
          out_d.end_of_string      = 1'b0;
          out_d.stage_overflow     = pend_ovf_q;
          pend_byte_d              = em_byte_q;
          pend_ovf_d               = em_ovf_q;
          n_d                      = n_q + 6'd1;
          state_d                  = S_TOP;
        end
      end
      S_FIN: begin
        if (pend_valid_q || end_q) begin
          if (out_free) begin
            out_valid_d          = 1'b1;
            out_d.out_byte       = pend_valid_q ? pend_byte_q : 8'h00;
            out_d.byte_valid     = pend_valid_q;
            out_d.end_of_string  = end_q;
            out_d.stage_overflow = pend_valid_q && pend_ovf_q;
            pend_valid_d         = 1'b0;
            if (end_q) begin
              cnt_d   = '0;
              smode_d = 1'b0;
            end
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Consumed bytes leave the head of the circular buffer.
    if (adv_en) begin
      head_d = wrap_add(head_q, adv_k);
      cnt_d  = cnt_q - adv_k;
    end

    if (emit_go) begin
      em_byte_d = emit_byte;
      em_ovf_d  = emit_ovf;
      state_d   = S_EMIT;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      cnt_q        <= '0;
      end_q        <= 1'b0;
      smode_q      <= 1'b0;
      j_q          <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      end_q        <= end_d;
      smode_q      <= smode_d;
      j_q          <= j_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    b1_q        <= b1_d;
    d1_q        <= d1_d;
    d1ok_q      <= d1ok_d;
    em_byte_q   <= em_byte_d;
    em_ovf_q    <= em_ovf_d;
    pend_byte_q <= pend_byte_d;
    pend_ovf_q  <= pend_ovf_d;
    out_q       <= out_d;
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_en_q <= 1'b1;
      rus_q    <= 1'b0;
      dig_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHexEn:   hex_en_q <= cfg_data_i[0];
        CfgRussian: rus_q    <= cfg_data_i[0];
        CfgDigits:  dig_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
